### hw/rtl/sle_pkg.sv
// Shared types and codes for the sorted list engine.
`default_nettype none

package sle_pkg;

	// Fixed field widths of the words on both channels
	localparam int DATA_W = 64;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 7;
	localparam int ST_W   = 2;

	// List capacity, tied to the position and count field widths
	localparam int DEPTH  = 64;

	// Operation codes
	localparam logic [CMD_W-1:0] CMD_INS  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PRE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REV  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RD   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ASC  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_DESC = 3'd7;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

	// Request from the front end to the list core
	typedef struct packed {
		logic              start;
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  pos;
	} sle_req_t;

	// Status and result from the list core
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] read_value;
		logic              in_order;
		logic [CNT_W-1:0]  entry_count;
		logic [ST_W-1:0]   status;
	} sle_res_t;

endpackage

`default_nettype wire

### hw/rtl/sle_core.sv
// List storage, sequencer and shared signed comparator of the sorted list engine.
`default_nettype none

module sle_core import sle_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire sle_req_t req,
	input  wire logic     take,
	output sle_res_t      res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// Sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_SHUP = 4'd2;
	localparam logic [3:0] S_SHDN = 4'd3;
	localparam logic [3:0] S_REVB = 4'd4;
	localparam logic [3:0] S_REVC = 4'd5;
	localparam logic [3:0] S_REVD = 4'd6;
	localparam logic [3:0] S_RDW  = 4'd7;
	localparam logic [3:0] S_CHK  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [3:0]        state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] tmp_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     tgt_q;
	logic [AW-1:0]     wa_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic              pend_q;
	logic [DATA_W-1:0] rdv_q;
	logic              ord_q;
	logic [ST_W-1:0]   st_q;

	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] cmp_a;
	logic [DATA_W-1:0] cmp_b;
	logic              le;
	logic              cnt_full;
	logic              cnt_zero;
	logic              pos_bad;

	assign cnt_full = (count_q == FULL_CNT);
	assign cnt_zero = (count_q == '0);
	assign pos_bad  = (XW'(req.pos) >= XW'(count_q));

	// Shared signed comparator: a <= b
	assign le = ($signed(cmp_a) <= $signed(cmp_b));

	// Memory address, write and comparator operand selection
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = val_q;
		cmp_a = rdata_q;
		cmp_b = val_q;
		case (state_q)
			S_IDLE: begin
				if (req.cmd == CMD_RD) begin
					raddr = AW'(req.pos);
				end
			end
			S_SCAN: begin
				raddr = AW'(j_q + CW'(1));
			end
			S_SHUP: begin
				raddr = AW'(j_q - CW'(1));
				we    = pend_q | (j_q == tgt_q);
				waddr = pend_q ? wa_q : AW'(tgt_q);
				wdata = pend_q ? rdata_q : val_q;
			end
			S_SHDN: begin
				raddr = AW'(j_q);
				we    = pend_q;
				waddr = wa_q;
				wdata = rdata_q;
			end
			S_REVB: begin
				raddr = hi_q;
			end
			S_REVC: begin
				we    = 1'b1;
				waddr = lo_q;
				wdata = rdata_q;
			end
			S_REVD: begin
				raddr = lo_q + AW'(1);
				we    = 1'b1;
				waddr = hi_q;
				wdata = tmp_q;
			end
			S_CHK: begin
				raddr = AW'(j_q);
				if (cmd_q == CMD_DESC) begin
					cmp_a = rdata_q;
					cmp_b = tmp_q;
				end else begin
					cmp_a = tmp_q;
					cmp_b = rdata_q;
				end
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_INS;
			val_q   <= '0;
			tmp_q   <= '0;
			count_q <= '0;
			j_q     <= '0;
			tgt_q   <= '0;
			wa_q    <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			pend_q  <= 1'b0;
			rdv_q   <= '0;
			ord_q   <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						cmd_q  <= req.cmd;
						val_q  <= req.value;
						rdv_q  <= '0;
						pend_q <= 1'b0;
						case (req.cmd)
							CMD_INS, CMD_PRE, CMD_APP: begin
								ord_q <= 1'b0;
								if (cnt_full) begin
									st_q    <= ST_FULL;
									state_q <= S_DONE;
								end else if (req.cmd == CMD_PRE) begin
									st_q    <= ST_OK;
									j_q     <= count_q;
									tgt_q   <= '0;
									state_q <= S_SHUP;
								end else if (req.cmd == CMD_APP || cnt_zero) begin
									st_q    <= ST_OK;
									j_q     <= count_q;
									tgt_q   <= count_q;
									state_q <= S_SHUP;
								end else begin
									// read of entry 0 already issued
									st_q    <= ST_OK;
									j_q     <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_REM: begin
								ord_q <= 1'b0;
								if (pos_bad) begin
									st_q    <= ST_BADPOS;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									j_q     <= CW'(req.pos) + CW'(1);
									state_q <= S_SHDN;
								end
							end
							CMD_REV: begin
								ord_q <= 1'b0;
								lo_q  <= '0;
								hi_q  <= AW'(count_q - CW'(1));
								if (cnt_zero) begin
									st_q    <= ST_EMPTY;
									state_q <= S_DONE;
								end else if (count_q == CW'(1)) begin
									st_q    <= ST_OK;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									state_q <= S_REVB;
								end
							end
							CMD_RD: begin
								ord_q <= 1'b0;
								if (pos_bad) begin
									st_q    <= ST_BADPOS;
									state_q <= S_DONE;
								end else begin
									st_q    <= ST_OK;
									state_q <= S_RDW;
								end
							end
							CMD_ASC, CMD_DESC: begin
								st_q <= ST_OK;
								j_q  <= CW'(1);
								if (count_q <= CW'(1)) begin
									ord_q   <= 1'b1;
									state_q <= S_DONE;
								end else begin
									ord_q   <= 1'b0;
									state_q <= S_CHK;
								end
							end
							default: begin
								ord_q   <= 1'b0;
								st_q    <= ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// forward scan for the first entry greater than the value
				S_SCAN: begin
					if (!le) begin
						tgt_q   <= j_q;
						j_q     <= count_q;
						state_q <= S_SHUP;
					end else if (j_q + CW'(1) == count_q) begin
						tgt_q   <= count_q;
						j_q     <= count_q;
						state_q <= S_SHUP;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				// open a slot at tgt, top entry first, then drop the value in
				S_SHUP: begin
					if (j_q != tgt_q) begin
						wa_q   <= AW'(j_q);
						j_q    <= j_q - CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= count_q + CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				// close the gap left by a removed entry
				S_SHDN: begin
					if (j_q != count_q) begin
						wa_q   <= AW'(j_q - CW'(1));
						j_q    <= j_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				// swap one pair per pass through the REVB, REVC and REVD states
				S_REVB: begin
					tmp_q   <= rdata_q;
					state_q <= S_REVC;
				end
				S_REVC: begin
					state_q <= S_REVD;
				end
				S_REVD: begin
					lo_q <= lo_q + AW'(1);
					hi_q <= hi_q - AW'(1);
					if ((lo_q + AW'(1)) < (hi_q - AW'(1))) begin
						state_q <= S_REVB;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RDW: begin
					rdv_q   <= rdata_q;
					state_q <= S_DONE;
				end
				// order check, previous entry held in tmp
				S_CHK: begin
					if (pend_q && !le) begin
						ord_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (j_q == count_q) begin
						ord_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						tmp_q  <= rdata_q;
						pend_q <= 1'b1;
						j_q    <= j_q + CW'(1);
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.busy        = (state_q != S_IDLE);
	assign res.done        = (state_q == S_DONE);
	assign res.read_value  = rdv_q;
	assign res.in_order    = ord_q;
	assign res.entry_count = CNT_W'(count_q);
	assign res.status      = st_q;

endmodule

`default_nettype wire

### hw/rtl/sorted_list_engine.sv
// Top level of the sorted list engine: handshakes and result register.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------------
//  in      | to block  | in_valid / in_stall  | cmd, data_value, position
//  out     | from block| out_valid / out_stall| read_value, in_order, entry_count, status
//
// One word is worked on at a time; in_stall is high from acceptance until the result
// moves into the output register, after which the next word can be taken. The busy
// time of insert, prepend, remove, reverse and order checks grows with the entry
// count; full, bad position, empty reverse, read, append and checks on up to one entry
// do not depend on it. Worst case is reversing a full list. Reset clears the count
// and control state but not the list storage. While the output register holds a
// stalled word, a finished result waits in the core and keeps in_stall high.
`default_nettype none

module sorted_list_engine import sle_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [CMD_W-1:0]         cmd,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic [POS_W-1:0]         position,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      read_value,
	output logic                          in_order,
	output logic [CNT_W-1:0]              entry_count,
	output logic [ST_W-1:0]               status
);

	sle_req_t          req;
	sle_res_t          res;
	logic              take;
	logic              out_valid_q;
	logic [DATA_W-1:0] read_value_q;
	logic              in_order_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [ST_W-1:0]   status_q;

	// Input side: the core takes a word only when idle
	assign in_stall  = res.busy;
	assign req.start = in_valid & ~res.busy;
	assign req.cmd   = cmd;
	assign req.value = data_value;
	assign req.pos   = position;

	sle_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.res    (res)
	);

	// Move a finished result into the output register when it is free
	assign take = res.done & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			read_value_q  <= res.read_value;
			in_order_q    <= res.in_order;
			entry_count_q <= res.entry_count;
			status_q      <= res.status;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign in_order    = in_order_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule

`default_nettype wire

### sim/sle_list_checker.sv
// Checker for the sorted list engine: tracks the list, predicts each result and compares.
`timescale 1ns / 100ps

module sle_list_checker import sle_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic [CMD_W-1:0]         cmd,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic signed [DATA_W-1:0] read_value,
	input  wire logic                     in_order,
	input  wire logic [CNT_W-1:0]         entry_count,
	input  wire logic [ST_W-1:0]          status,
	output int                            fail_count,
	output int                            pending,
	output int                            list_len
);

	localparam int EXP_SLOTS = 256;

	// One predicted result word
	typedef struct packed {
		logic signed [DATA_W-1:0] rd;
		logic                     ord;
		logic [CNT_W-1:0]         cnt;
		logic [ST_W-1:0]          st;
	} list_result_t;

	logic signed [DATA_W-1:0] list_mem [DEPTH];
	int                       list_n;
	int                       fails;
	list_result_t             exp_fifo [EXP_SLOTS];
	int                       exp_wr;
	int                       exp_rd;

	// Apply one operation to the tracked list and return the result it gives
	function automatic list_result_t apply_list_op(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] v, input logic [POS_W-1:0] p);
		list_result_t             r;
		int                       at;
		int                       i;
		logic signed [DATA_W-1:0] t;
		r = '0;
		r.st = ST_OK;
		case (op)
			CMD_INS, CMD_PRE, CMD_APP: begin
				if (list_n >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					// sorted insert goes after every entry <= value
					if (op == CMD_INS) begin
						at = 0;
						while (at < list_n && list_mem[at] <= v)
							at++;
					end else if (op == CMD_PRE) begin
						at = 0;
					end else begin
						at = list_n;
					end
					for (i = list_n; i > at; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[at] = v;
					list_n++;
				end
			end
			CMD_REM: begin
				if (int'(p) >= list_n) begin
					r.st = ST_BADPOS;
				end else begin
					for (i = int'(p); i + 1 < list_n; i++)
						list_mem[i] = list_mem[i+1];
					list_n--;
				end
			end
			CMD_REV: begin
				if (list_n == 0) begin
					r.st = ST_EMPTY;
				end else begin
					for (i = 0; i < list_n / 2; i++) begin
						t = list_mem[i];
						list_mem[i] = list_mem[list_n-1-i];
						list_mem[list_n-1-i] = t;
					end
				end
			end
			CMD_RD: begin
				if (int'(p) >= list_n)
					r.st = ST_BADPOS;
				else
					r.rd = list_mem[p];
			end
			CMD_ASC: begin
				r.ord = 1'b1;
				for (i = 1; i < list_n; i++)
					if (list_mem[i-1] > list_mem[i])
						r.ord = 1'b0;
			end
			CMD_DESC: begin
				r.ord = 1'b1;
				for (i = 1; i < list_n; i++)
					if (list_mem[i-1] < list_mem[i])
						r.ord = 1'b0;
			end
			default: ;
		endcase
		r.cnt = CNT_W'(list_n);
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
			input logic signed [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Watch both channels: predict on each accepted input word, compare each result word
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_n = 0;
			fails = 0;
			exp_wr = 0;
			exp_rd = 0;
			fail_count <= 0;
			pending <= 0;
			list_len <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				exp_fifo[exp_wr % EXP_SLOTS] = apply_list_op(cmd, data_value, position);
				exp_wr++;
			end
			if (out_valid && !out_stall) begin
				if (exp_wr == exp_rd) begin
					$error("result word with nothing expected");
					fails++;
				end else begin
					want = exp_fifo[exp_rd % EXP_SLOTS];
					exp_rd++;
					check_field("read_value", want.rd, read_value);
					check_field("in_order", {63'd0, want.ord}, {63'd0, in_order});
					check_field("entry_count", {57'd0, want.cnt}, {57'd0, entry_count});
					check_field("status", {62'd0, want.st}, {62'd0, status});
				end
			end
			fail_count <= fails;
			pending <= exp_wr - exp_rd;
			list_len <= list_n;
		end
	end

endmodule

### sim/tb_sorted_list_engine.sv
// Testbench top for the sorted list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_list_engine import sle_pkg::*; ();

	localparam int ITEMS = 1950;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] data_value;
	logic [POS_W-1:0]         position;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] read_value;
	logic                     in_order;
	logic [CNT_W-1:0]         entry_count;
	logic [ST_W-1:0]          status;

	int fail_count;
	int pending;
	int list_len;
	int sent_words = 0;
	bit idle_on = 1'b1;

	sorted_list_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .data_value(data_value), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .in_order(in_order),
		.entry_count(entry_count), .status(status)
	);

	sle_list_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .data_value(data_value), .position(position),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .in_order(in_order),
		.entry_count(entry_count), .status(status),
		.fail_count(fail_count), .pending(pending), .list_len(list_len)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Overall run limit
	initial begin
		#20_000_000;
		$display("FAIL sorted_list_engine");
		$finish;
	end

	// Value mix: narrow range for duplicates, extremes, full-width random
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return DATA_W'($signed($urandom_range(0, 16)) - 8);
			1: begin
				case ($urandom_range(0, 3))
					0: return 64'sh7FFF_FFFF_FFFF_FFFF;
					1: return 64'sh8000_0000_0000_0000;
					2: return '0;
					default: return -64'sd1;
				endcase
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly a valid position, sometimes anywhere in the field
	function automatic logic [POS_W-1:0] rand_pos();
		if (list_len > 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, list_len - 1));
		return POS_W'($urandom_range(0, 63));
	endfunction

	// Pick one of the three adding operations
	function automatic logic [CMD_W-1:0] CMD_CMD_ADD();
		case ($urandom_range(0, 3))
			0: return CMD_PRE;
			1: return CMD_APP;
			default: return CMD_INS;
		endcase
	endfunction

	// Offer one input word and wait for it to be taken
	task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
			input logic [POS_W-1:0] p);
		idle_on = !(sent_words >= 1000 && sent_words < 1300);
		if (idle_on && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		data_value <= v;
		position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_words++;
	endtask

	// Receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent_words >= 600) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			out_stall <= idle_on && ($urandom_range(0, 99) < 30);
		end
	end

	// Reset, directed words, random episodes, then drain and verdict
	initial begin
		int wait_cycles;
		logic [CMD_W-1:0] op;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_RD;
		data_value <= '0;
		position <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list cases
		send_word(CMD_REV, '0, '0);
		send_word(CMD_RD, '0, 6'd0);
		send_word(CMD_REM, '0, 6'd63);
		send_word(CMD_ASC, '0, '0);
		send_word(CMD_DESC, '0, '0);
		// extremes and equal values
		send_word(CMD_INS, 64'sh7FFF_FFFF_FFFF_FFFF, 6'd63);
		send_word(CMD_INS, 64'sh8000_0000_0000_0000, '0);
		send_word(CMD_INS, '0, '0);
		send_word(CMD_INS, -64'sd1, '0);
		send_word(CMD_INS, '0, '0);
		send_word(CMD_ASC, '0, '0);
		send_word(CMD_PRE, 64'sd5, '0);
		send_word(CMD_APP, -64'sd5, '0);
		send_word(CMD_ASC, '0, '0);
		send_word(CMD_DESC, '0, '0);
		send_word(CMD_RD, '0, 6'd0);
		send_word(CMD_RD, '0, 6'd6);
		send_word(CMD_RD, '0, 6'd7);
		send_word(CMD_REM, '0, 6'd0);
		send_word(CMD_REM, '0, 6'd5);
		send_word(CMD_REV, '0, '0);
		send_word(CMD_DESC, '0, '0);
		send_word(CMD_RD, '0, 6'd63);
		send_word(CMD_REM, '0, 6'd2);
		send_word(CMD_RD, '0, 6'd0);

		while (sent_words < ITEMS) begin
			case ($urandom_range(0, 3))
				0: begin
					// fill to the top, then a few dropped adds
					while (list_len < DEPTH)
						send_word(CMD_CMD_ADD(), rand_value(), POS_W'($urandom));
					repeat ($urandom_range(1, 3))
						send_word(CMD_CMD_ADD(), rand_value(), POS_W'($urandom));
					send_word(CMD_ASC, '0, '0);
					send_word(CMD_RD, '0, 6'd63);
				end
				1: begin
					// drain to empty, then poke the empty list
					while (list_len > 0)
						send_word($urandom_range(0, 3) == 0 ? CMD_RD : CMD_REM, '0, rand_pos());
					send_word(CMD_REV, '0, '0);
					send_word(CMD_REM, '0, POS_W'($urandom));
					send_word(CMD_RD, '0, POS_W'($urandom));
					send_word($urandom_range(0, 1) ? CMD_ASC : CMD_DESC, '0, '0);
				end
				2: begin
					// sorted build, then order checks around a reverse
					repeat ($urandom_range(1, 20))
						send_word(CMD_INS, rand_value(), POS_W'($urandom));
					send_word(CMD_ASC, '0, '0);
					send_word(CMD_DESC, '0, '0);
					send_word(CMD_REV, '0, '0);
					send_word(CMD_ASC, '0, '0);
					send_word(CMD_DESC, '0, '0);
					repeat ($urandom_range(1, 4))
						send_word(CMD_RD, '0, rand_pos());
				end
				default: begin
					// free mix of every operation
					repeat ($urandom_range(20, 60)) begin
						op = CMD_W'($urandom_range(0, 7));
						send_word(op, rand_value(), rand_pos());
					end
				end
			endcase
		end
		in_valid <= 1'b0;

		// wait for outstanding results, then a quiet tail
		wait_cycles = 0;
		do begin
			@(posedge clk);
			wait_cycles++;
		end while (pending != 0 && wait_cycles < 20000);
		repeat (150) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS sorted_list_engine");
		else
			$display("FAIL sorted_list_engine");
		$finish;
	end

endmodule

### sorted_list_engine.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_core.sv
hw/rtl/sorted_list_engine.sv
sim/sle_list_checker.sv
sim/tb_sorted_list_engine.sv
